FILE: rtl/fsnp_pkg.sv
package fsnp_pkg;

   localparam int DIGIT_DEPTH = 20;
   localparam int DIGIT_IDX_W = $clog2(DIGIT_DEPTH + 1);

   // Reciprocal of ten scaled by 2^35, exact for every 32-bit dividend.
   localparam logic [31:0] RECIP_10 = 32'hCCCC_CCCD;
   localparam int RECIP_SHIFT = 35;

   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_LOW_X   = 8'h78;
   localparam logic [7:0] CH_UP_X    = 8'h58;
   localparam logic [7:0] CH_LOW_C   = 8'h63;
   localparam logic [7:0] CH_LOW_D   = 8'h64;
   localparam logic [7:0] CH_LOW_I   = 8'h69;
   localparam logic [7:0] CH_LOW_U   = 8'h75;
   localparam logic [7:0] CH_LOW_P   = 8'h70;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_LOW_N   = 8'h6E;
   localparam logic [7:0] CH_LOW_L   = 8'h6C;
   localparam logic [7:0] CH_RPAREN  = 8'h29;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_DIV  = 4'b0010,
      ST_PFX  = 4'b0100,
      ST_DIG  = 4'b1000
   } state_type;

   typedef enum logic [1:0] {
      PFX_CHAR,
      PFX_HEX,
      PFX_NIL
   } pfx_kind_type;

   function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
      logic [7:0] c;
      if (d < 4'd10) begin
         c = CH_ZERO + {4'd0, d};
      end else if (upper) begin
         c = 8'h41 + {4'd0, d - 4'd10};
      end else begin
         c = 8'h61 + {4'd0, d - 4'd10};
      end
      return c;
   endfunction

   function automatic logic [7:0] pfx_char(input pfx_kind_type kind, input logic [2:0] idx,
                                           input logic [7:0] ch);
      logic [7:0] c;
      c = ch;
      unique case (kind)
         PFX_CHAR: c = ch;
         PFX_HEX:  c = (idx == 3'd0) ? CH_ZERO : CH_LOW_X;
         PFX_NIL: begin
            unique case (idx)
               3'd0:    c = CH_LPAREN;
               3'd1:    c = CH_LOW_N;
               3'd2:    c = CH_LOW_I;
               3'd3:    c = CH_LOW_L;
               default: c = CH_RPAREN;
            endcase
         end
         default:  c = ch;
      endcase
      return c;
   endfunction

endpackage

FILE: rtl/fsnp_if.sv
interface fsnp_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  fmt_byte;
   logic [63:0] arg_value;
   logic        end_of_string;

   modport source (output valid, fmt_byte, arg_value, end_of_string, input ready);
   modport sink   (input valid, fmt_byte, arg_value, end_of_string, output ready);
endinterface

interface fsnp_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_char;
   logic        last_of_run;
   logic [31:0] char_count;

   modport source (output valid, out_char, last_of_run, char_count, input ready);
   modport sink   (input valid, out_char, last_of_run, char_count, output ready);
endinterface

FILE: rtl/fsnp_digit_unit.sv
module fsnp_digit_unit
   import fsnp_pkg::*;
(
   input  logic [63:0] value_i,
   input  logic        hex_i,
   output logic [63:0] quot_o,
   output logic [3:0]  digit_o
);

   logic [63:0] prod;
   logic [28:0] q10;
   logic [31:0] ten_q;
   logic [31:0] rem10;

   // Decimal values never exceed 32 bits, so one 32x32 product gives the quotient.
   assign prod  = value_i[31:0] * RECIP_10;
   assign q10   = prod[63:RECIP_SHIFT];
   assign ten_q = {q10, 3'b000} + {2'b00, q10, 1'b0};
   assign rem10 = value_i[31:0] - ten_q;

   always_comb begin
      if (hex_i) begin
         quot_o  = {4'd0, value_i[63:4]};
         digit_o = value_i[3:0];
      end else begin
         quot_o  = {35'd0, q10};
         digit_o = rem10[3:0];
      end
   end

endmodule

FILE: rtl/format_string_number_printer_core.sv
// Channel  Direction  Payload                                  Accepted when
// req      in         fmt_byte, arg_value, end_of_string       req.valid && req.ready
// rsp      out        out_char, last_of_run, char_count        rsp.valid && rsp.ready
//
// An item that prints nothing finishes in the cycle it is accepted. Otherwise the
// block works out its digits in the shared divide unit (up to 10 decimal or
// 16 hex digits), least significant first, then sends each printed character.
// req.ready is high only while idle.
// Reset clears the sequencer, the pending flag, the count and the output valid flag.
// A stalled rsp holds the current character and pauses the prefix and digit states.
module format_string_number_printer_core
   import fsnp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   fsnp_req_if.sink   req,
   fsnp_rsp_if.source rsp
);

   state_type                state_ff, state_in;
   logic                     pending_ff, pending_in;
   logic [31:0]              count_ff, count_in;
   logic                     eos_ff, eos_in;
   pfx_kind_type             kind_ff, kind_in;
   logic [7:0]               ch_ff, ch_in;
   logic                     pfx_ff, pfx_in;
   logic [2:0]               pfx_len_ff, pfx_len_in;
   logic [2:0]               pfx_idx_ff, pfx_idx_in;
   logic                     num_ff, num_in;
   logic                     hex_ff, hex_in;
   logic                     upper_ff, upper_in;
   logic [63:0]              value_ff, value_in;
   logic [DIGIT_IDX_W-1:0]   len_ff, len_in;
   logic [3:0]               buf_ff [DIGIT_DEPTH];
   logic                     buf_we;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [7:0]               rsp_char_ff, rsp_char_in;
   logic                     rsp_last_ff, rsp_last_in;
   logic [31:0]              rsp_count_ff, rsp_count_in;

   // Decode of the accepted item.
   logic                     dec_out, dec_pfx, dec_num, dec_hex, dec_upper;
   pfx_kind_type             dec_kind;
   logic [7:0]               dec_ch;
   logic [2:0]               dec_pfx_len;
   logic [63:0]              dec_value;
   logic [31:0]              w;
   logic [31:0]              w_neg;

   logic [63:0]              quot;
   logic [3:0]               digit;
   logic                     accept, can_emit, emit, emit_last;
   logic [7:0]               emit_char;
   logic [DIGIT_IDX_W-1:0]   rd_idx;

   fsnp_digit_unit u_digit (
      .value_i (value_ff),
      .hex_i   (hex_ff),
      .quot_o  (quot),
      .digit_o (digit)
   );

   assign req.ready     = (state_ff == ST_IDLE);
   assign accept        = req.valid && req.ready;
   assign can_emit      = !rsp_valid_ff || rsp.ready;
   assign rd_idx        = len_ff - DIGIT_IDX_W'(1);

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.out_char    = rsp_char_ff;
   assign rsp.last_of_run = rsp_last_ff;
   assign rsp.char_count  = rsp_count_ff;

   assign w     = req.arg_value[31:0];
   assign w_neg = ~w + 32'd1;

   // Work out which prefix characters and which number an item prints.
   always_comb begin
      dec_out     = 1'b0;
      dec_pfx     = 1'b0;
      dec_num     = 1'b0;
      dec_hex     = 1'b0;
      dec_upper   = 1'b0;
      dec_kind    = PFX_CHAR;
      dec_ch      = req.fmt_byte;
      dec_pfx_len = 3'd1;
      dec_value   = {32'd0, w};
      if (pending_ff) begin
         unique case (req.fmt_byte)
            CH_LOW_C: begin
               dec_out = 1'b1;
               dec_pfx = 1'b1;
               dec_ch  = req.arg_value[7:0];
            end
            CH_LOW_D, CH_LOW_I: begin
               dec_out = 1'b1;
               dec_num = 1'b1;
               if (w[31]) begin
                  dec_pfx   = 1'b1;
                  dec_ch    = CH_MINUS;
                  dec_value = {32'd0, w_neg};
               end
            end
            CH_LOW_U: begin
               dec_out = 1'b1;
               dec_num = 1'b1;
            end
            CH_LOW_X, CH_UP_X: begin
               dec_out   = 1'b1;
               dec_num   = 1'b1;
               dec_hex   = 1'b1;
               dec_upper = (req.fmt_byte == CH_UP_X);
            end
            CH_LOW_P: begin
               dec_out = 1'b1;
               dec_pfx = 1'b1;
               dec_hex = 1'b1;
               if (req.arg_value == 64'd0) begin
                  dec_kind    = PFX_NIL;
                  dec_pfx_len = 3'd5;
               end else begin
                  dec_kind    = PFX_HEX;
                  dec_pfx_len = 3'd2;
                  dec_num     = 1'b1;
                  dec_value   = req.arg_value;
               end
            end
            CH_PERCENT: begin
               dec_out = 1'b1;
               dec_pfx = 1'b1;
            end
            default: begin
               dec_out = 1'b0;
            end
         endcase
      end else if (req.fmt_byte != CH_PERCENT) begin
         dec_out = 1'b1;
         dec_pfx = 1'b1;
      end
   end

   always_comb begin
      state_in   = state_ff;
      pending_in = pending_ff;
      count_in   = count_ff;
      eos_in     = eos_ff;
      kind_in    = kind_ff;
      ch_in      = ch_ff;
      pfx_in     = pfx_ff;
      pfx_len_in = pfx_len_ff;
      pfx_idx_in = pfx_idx_ff;
      num_in     = num_ff;
      hex_in     = hex_ff;
      upper_in   = upper_ff;
      value_in   = value_ff;
      len_in     = len_ff;
      buf_we     = 1'b0;
      emit       = 1'b0;
      emit_last  = 1'b0;
      emit_char  = pfx_char(kind_ff, pfx_idx_ff, ch_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pending_in = !pending_ff && (req.fmt_byte == CH_PERCENT) && !req.end_of_string;
               eos_in     = req.end_of_string;
               kind_in    = dec_kind;
               ch_in      = dec_ch;
               pfx_in     = dec_pfx;
               pfx_len_in = dec_pfx_len;
               pfx_idx_in = 3'd0;
               num_in     = dec_num;
               hex_in     = dec_hex;
               upper_in   = dec_upper;
               value_in   = dec_value;
               len_in     = '0;
               if (!dec_out) begin
                  // Nothing printed: the end of the string takes effect at once.
                  if (req.end_of_string) begin
                     count_in = 32'd0;
                  end
               end else if (dec_num) begin
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_PFX;
               end
            end
         end
         ST_DIV: begin
            // One digit per cycle, least significant first.
            buf_we   = 1'b1;
            value_in = quot;
            len_in   = len_ff + DIGIT_IDX_W'(1);
            if (quot == 64'd0 || len_ff == DIGIT_IDX_W'(DIGIT_DEPTH - 1)) begin
               state_in = pfx_ff ? ST_PFX : ST_DIG;
            end
         end
         ST_PFX: begin
            emit_char = pfx_char(kind_ff, pfx_idx_ff, ch_ff);
            if (can_emit) begin
               emit       = 1'b1;
               pfx_idx_in = pfx_idx_ff + 3'd1;
               if (pfx_idx_ff == pfx_len_ff - 3'd1) begin
                  emit_last = !num_ff;
                  state_in  = num_ff ? ST_DIG : ST_IDLE;
               end
            end
         end
         ST_DIG: begin
            emit_char = digit_char(buf_ff[rd_idx], upper_ff);
            if (can_emit) begin
               emit   = 1'b1;
               len_in = rd_idx;
               if (len_ff == DIGIT_IDX_W'(1)) begin
                  emit_last = 1'b1;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (emit) begin
         count_in = (emit_last && eos_ff) ? 32'd0 : count_ff + 32'd1;
      end
   end

   // A number item without a prefix starts its digits straight after the divide.
   // Only a minus sign or "0x" precede digits; "(nil)" prints no digits.

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_count_in = rsp_count_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = emit_char;
         rsp_last_in  = emit_last;
         rsp_count_in = count_ff + 32'd1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pending_ff   <= 1'b0;
         count_ff     <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pending_ff   <= pending_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      eos_ff       <= eos_in;
      kind_ff      <= kind_in;
      ch_ff        <= ch_in;
      pfx_ff       <= pfx_in;
      pfx_len_ff   <= pfx_len_in;
      pfx_idx_ff   <= pfx_idx_in;
      num_ff       <= num_in;
      hex_ff       <= hex_in;
      upper_ff     <= upper_in;
      value_ff     <= value_in;
      len_ff       <= len_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_count_ff <= rsp_count_in;
      if (buf_we) begin
         buf_ff[len_ff] <= digit;
      end
   end

endmodule

FILE: rtl/fsnp_checker.sv
module fsnp_checker
   import fsnp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_out_char,
   input logic        rsp_last_of_run,
   input logic [31:0] rsp_char_count
);

   logic        mid_run_ff;
   logic [31:0] prev_count_ff;

   // Remember whether the last delivered item left its run unfinished.
   always_ff @(posedge clock) begin
      if (reset) begin
         mid_run_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         mid_run_ff <= !rsp_last_of_run;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         prev_count_ff <= rsp_char_count;
      end
   end

   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_char)
                                  && $stable(rsp_last_of_run) && $stable(rsp_char_count))
      else $error("stalled result changed");

   a_busy_mid_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_run |-> !req_ready)
      else $error("input taken before the run finished");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && mid_run_ff |-> rsp_char_count == prev_count_ff + 32'd1)
      else $error("character count did not advance by one within a run");

endmodule

bind format_string_number_printer_core fsnp_checker u_fsnp_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req.ready),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_out_char    (rsp.out_char),
   .rsp_last_of_run (rsp.last_of_run),
   .rsp_char_count  (rsp.char_count)
);

FILE: bench/format_string_number_printer_core_tb.sv
module format_string_number_printer_core_tb;
   import fsnp_pkg::*;

   // The run is bounded by a cycle counter, whose limit only catches a hang.
   localparam int CYCLE_LIMIT    = 1_000_000;
   // Number of items in the random part, after the directed rows.
   localparam int RANDOM_ITEMS   = 255;
   // The longest item is a pointer with sixteen hex digits.
   localparam int DRAIN_CYCLES   = 60;
   // The string conversion is not supported, so this byte acts as an unknown specifier.
   localparam logic [7:0] CH_LOW_S = 8'h73;
   localparam logic [7:0] SPEC_CODES [9] = '{CH_LOW_C, CH_LOW_D, CH_LOW_I, CH_LOW_U,
                                             CH_LOW_X, CH_UP_X, CH_LOW_P, CH_PERCENT,
                                             CH_LOW_S};

   typedef logic [7:0] char_q_type[$];

   typedef struct packed {
      logic [7:0]  ch;
      logic        last;
      logic [31:0] count;
   } printed_char_type;

   // One directed stimulus row. When typed is set, text holds the characters
   // that the row must print, written out by hand.
   typedef struct {
      logic [7:0]  fmt;
      logic [63:0] arg;
      logic        eos;
      bit          typed;
      string       text;
   } format_row_type;

   logic clock;
   logic reset;
   logic sink_ready = 1'b0;

   fsnp_req_if req();
   fsnp_rsp_if rsp();

   format_string_number_printer_core dut (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   assign rsp.ready = sink_ready;

   // Predictor state: the armed percent flag and the running character count.
   bit                 percent_armed;
   logic [31:0]        chars_printed;
   printed_char_type   expected_chars[$];
   printed_char_type   oldest_char;
   format_row_type     format_rows[$];
   int                 error_count;
   int                 burst_left;
   int                 cycle_count;

   // Receiver pattern state.
   int              sink_mode;
   int              sink_window;
   int              sink_run;
   bit              sink_hold;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Digits of a value in the given radix, most significant first, with no
   // leading zeros. Zero prints as a single digit.
   function automatic char_q_type number_text(logic [63:0] value, int unsigned radix,
                                              bit upper);
      char_q_type  text;
      logic [63:0] rest;
      logic [3:0]  digit;
      rest = value;
      do begin
         digit = 4'(rest % radix);
         if (digit < 4'd10) begin
            text.push_front(CH_ZERO + 8'(digit));
         end else begin
            text.push_front((upper ? 8'h41 : 8'h61) + 8'(digit) - 8'd10);
         end
         rest = rest / radix;
      end while (rest != 0);
      return text;
   endfunction

   // Characters printed by one format byte. This also moves the armed percent
   // flag, but leaves the count to the caller.
   function automatic char_q_type render_item(logic [7:0] fmt, logic [63:0] arg);
      char_q_type  text;
      char_q_type  digits;
      logic [31:0] word;
      word = arg[31:0];
      if (percent_armed) begin
         percent_armed = 1'b0;
         case (fmt)
            CH_LOW_C: text.push_back(arg[7:0]);
            CH_LOW_D, CH_LOW_I: begin
               if (word[31]) begin
                  text.push_back(CH_MINUS);
                  word = -word;
               end
               digits = number_text({32'd0, word}, 10, 1'b0);
            end
            CH_LOW_U: digits = number_text({32'd0, word}, 10, 1'b0);
            CH_LOW_X: digits = number_text({32'd0, word}, 16, 1'b0);
            CH_UP_X:  digits = number_text({32'd0, word}, 16, 1'b1);
            CH_LOW_P: begin
               if (arg == 64'd0) begin
                  text = {CH_LPAREN, CH_LOW_N, CH_LOW_I, CH_LOW_L, CH_RPAREN};
               end else begin
                  text.push_back(CH_ZERO);
                  text.push_back(CH_LOW_X);
                  digits = number_text(arg, 16, 1'b0);
               end
            end
            CH_PERCENT: text.push_back(CH_PERCENT);
            default: ;
         endcase
         foreach (digits[k]) text.push_back(digits[k]);
      end else if (fmt == CH_PERCENT) begin
         percent_armed = 1'b1;
      end else begin
         text.push_back(fmt);
      end
      return text;
   endfunction

   // Called once per accepted item. It queues the characters that the item
   // must print, each tagged with the running count and the last flag.
   function automatic void expect_item(logic [7:0] fmt, logic [63:0] arg, logic eos,
                                       bit typed, string text);
      char_q_type       chars;
      printed_char_type entry;
      chars = render_item(fmt, arg);
      if (typed) begin
         chars.delete();
         for (int k = 0; k < text.len(); k++) chars.push_back(text[k]);
      end
      foreach (chars[k]) begin
         chars_printed = chars_printed + 32'd1;
         entry.ch      = chars[k];
         entry.last    = (k == chars.size() - 1);
         entry.count   = chars_printed;
         expected_chars.push_back(entry);
      end
      // The end of the string clears the flag and the count after this byte.
      if (eos) begin
         percent_armed = 1'b0;
         chars_printed = 32'd0;
      end
   endfunction

   function automatic void add_row(logic [7:0] fmt, logic [63:0] arg, logic eos,
                                   bit typed, string text);
      format_row_type row;
      row.fmt   = fmt;
      row.arg   = arg;
      row.eos   = eos;
      row.typed = typed;
      row.text  = text;
      format_rows.push_back(row);
   endfunction

   // The sender works in bursts. Most bursts are short with brief gaps
   // between them, so that gaps land on every phase of a long
   // conversion, and some are long stretches with no gap at all.
   function automatic int next_gap();
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      if ($urandom_range(0, 4) == 0) begin
         burst_left = $urandom_range(20, 40);
         return 0;
      end
      burst_left = $urandom_range(0, 11);
      return ($urandom_range(0, 5) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
   endfunction

   // Drives one item at a falling edge and holds it until a rising edge sees
   // valid and ready together. The task returns at the next falling edge, so
   // the following item can be driven without lowering valid in between.
   task automatic send_item(logic [7:0] fmt, logic [63:0] arg, logic eos, bit typed,
                            string text, int gap);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req.valid         <= 1'b1;
      req.fmt_byte      <= fmt;
      req.arg_value     <= arg;
      req.end_of_string <= eos;
      do begin
         @(posedge clock);
      end while (req.ready !== 1'b1);
      expect_item(fmt, arg, eos, typed, text);
      @(negedge clock);
   endtask

   // The receiver changes its behavior every window of cycles: always ready,
   // ready at random three times in four, a short periodic stall, or long
   // stalls that hold a character.
   always @(negedge clock) begin
      if (sink_window == 0) begin
         sink_window = $urandom_range(50, 150);
         sink_mode   = $urandom_range(0, 3);
         sink_run    = 0;
      end
      sink_window--;
      case (sink_mode)
         0: sink_ready <= 1'b1;
         1: sink_ready <= ($urandom_range(0, 3) != 0);
         2: sink_ready <= (sink_window % 3 != 0);
         default: begin
            if (sink_run == 0) begin
               sink_hold = !sink_hold;
               sink_run  = sink_hold ? $urandom_range(1, 10) : $urandom_range(5, 20);
            end
            sink_run--;
            sink_ready <= sink_hold;
         end
      endcase
   end

   // Every character taken from the block is compared with the oldest one
   // still expected.
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
         if (expected_chars.size() == 0) begin
            error_count++;
            $display("%0t: unexpected item char %h last %b count %0d", $time,
                     rsp.out_char, rsp.last_of_run, rsp.char_count);
         end else begin
            oldest_char = expected_chars.pop_front();
            if (rsp.out_char !== oldest_char.ch || rsp.last_of_run !== oldest_char.last ||
                rsp.char_count !== oldest_char.count) begin
               error_count++;
               $display("%0t: expected char %h last %b count %0d, got char %h last %b count %0d",
                        $time, oldest_char.ch, oldest_char.last, oldest_char.count,
                        rsp.out_char, rsp.last_of_run, rsp.char_count);
            end
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      logic [7:0]  fmt;
      logic [63:0] arg;
      logic        eos;
      bit          after_percent;
      int          pick;

      req.valid         <= 1'b0;
      req.fmt_byte      <= 8'd0;
      req.arg_value     <= 64'd0;
      req.end_of_string <= 1'b0;
      reset             <= 1'b1;
      percent_armed   = 1'b0;
      chars_printed   = 32'd0;
      error_count     = 0;
      burst_left      = 0;
      sink_window     = 0;
      sink_hold       = 1'b0;
      after_percent   = 1'b0;

      // Directed rows: plain bytes at both ends of the range, every conversion
      // with its extreme arguments, an unknown specifier, a percent that ends
      // the string, and a string end that clears the count.
      add_row("A",        64'd0,                   1'b0, 1'b1, "A");
      add_row(8'h00,      '1,                      1'b0, 1'b0, "");
      add_row(8'hFF,      64'd0,                   1'b1, 1'b0, "");
      add_row(CH_PERCENT, 64'd0,                   1'b0, 1'b1, "");
      add_row(CH_LOW_C,   64'hFFFF_FFFF_FFFF_FF5A, 1'b0, 1'b1, "Z");
      add_row(CH_PERCENT, 64'd0,                   1'b0, 1'b1, "");
      add_row(CH_LOW_D,   64'hFFFF_FFFF_8000_0000, 1'b0, 1'b1, "-2147483648");
      add_row(CH_PERCENT, 64'd0,                   1'b0, 1'b1, "");
      add_row(CH_LOW_I,   64'h1234_5678_7FFF_FFFF, 1'b0, 1'b1, "2147483647");
      add_row(CH_PERCENT, 64'd0,                   1'b0, 1'b1, "");
      add_row(CH_LOW_U,   64'h0000_0000_FFFF_FFFF, 1'b0, 1'b1, "4294967295");
      add_row(CH_PERCENT, 64'd0,                   1'b0, 1'b1, "");
      add_row(CH_LOW_X,   64'hFFFF_FFFF_DEAD_BEEF, 1'b0, 1'b1, "deadbeef");
      add_row(CH_PERCENT, 64'd0,                   1'b0, 1'b1, "");
      add_row(CH_UP_X,    64'hFFFF_FFFF_0000_0000, 1'b0, 1'b1, "0");
      add_row(CH_PERCENT, 64'd0,                   1'b0, 1'b1, "");
      add_row(CH_LOW_P,   64'd0,                   1'b0, 1'b1, "(nil)");
      add_row(CH_PERCENT, 64'd0,                   1'b0, 1'b1, "");
      add_row(CH_LOW_P,   '1,                      1'b0, 1'b1, "0xffffffffffffffff");
      add_row(CH_PERCENT, 64'd0,                   1'b0, 1'b1, "");
      add_row(CH_PERCENT, 64'd0,                   1'b0, 1'b1, "%");
      add_row(CH_PERCENT, 64'd0,                   1'b0, 1'b1, "");
      add_row(CH_LOW_S,   64'd0,                   1'b0, 1'b1, "");
      add_row(CH_PERCENT, 64'd0,                   1'b1, 1'b1, "");
      add_row("B",        64'd0,                   1'b1, 1'b1, "B");

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (format_rows[r]) begin
         send_item(format_rows[r].fmt, format_rows[r].arg, format_rows[r].eos,
                   format_rows[r].typed, format_rows[r].text, next_gap());
      end

      // Random part. Many items form well-shaped conversions: a percent
      // followed by a known specifier with a random argument. The rest is
      // plain text, stray bytes after a percent, and string ends that fall
      // anywhere, including right after a percent.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (after_percent) begin
            pick = $urandom_range(0, 11);
            fmt  = (pick < 9) ? SPEC_CODES[pick] : 8'($urandom_range(0, 255));
         end else begin
            fmt = ($urandom_range(0, 9) < 4) ? CH_PERCENT : 8'($urandom_range(0, 255));
         end
         // Arguments mix full random words with zero, short values, the
         // sign boundary and all ones, so that every digit count shows up.
         arg = {$urandom, $urandom};
         case ($urandom_range(0, 7))
            0: arg = 64'd0;
            1: arg = arg >> $urandom_range(1, 63);
            2: arg[31:0] = ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'hFFFF_FFFF;
            3: arg = '1;
            4: arg = 64'($urandom_range(0, 20));
            default: ;
         endcase
         eos = ($urandom_range(0, 15) == 0);
         after_percent = !after_percent && fmt == CH_PERCENT && !eos;
         send_item(fmt, arg, eos, 1'b0, "", next_gap());
      end
      req.valid <= 1'b0;

      // Wait for every expected character, then a little longer so that any
      // extra character from the block is caught.
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

FILE: files.f
rtl/fsnp_pkg.sv
rtl/fsnp_if.sv
rtl/fsnp_digit_unit.sv
rtl/format_string_number_printer_core.sv
rtl/fsnp_checker.sv
bench/format_string_number_printer_core_tb.sv
